// ===== src/tlq_pkg.sv =====
package tlq_pkg;

	localparam int DEF_LOG_DEPTH = 1024;
	localparam int DEF_TIME_BITS = 32;

	localparam int REQ_W    = 2;
	localparam int FIELD_W  = 32;
	localparam int STATUS_W = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND = 2'd0,
		REQ_QUERY  = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_code_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_NOT_INC    = 2'd2,
		ST_BAD_WINDOW = 2'd3
	} status_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_APP_CHK,
		S_APP_ADD,
		S_Q_CHK_LO,
		S_Q_CHK_HI,
		S_Q_CHK_ORD,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_COV_DIFF,
		S_COV_SUB,
		S_ON_SUB,
		S_RESP
	} state_t;

	// Search control from the sequencer.
	typedef struct packed {
		logic init;   // load lo = 0, hi = entry count
		logic step;   // narrow the range by one probe
		logic below;  // probed stamp is below the target
	} srch_ctl_t;

endpackage

// ===== src/tlq_in_if.sv =====
interface tlq_in_if
	import tlq_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [FIELD_W-1:0] time_a;
	logic [FIELD_W-1:0] time_b;

	modport source (output valid, req_type, time_a, time_b, input ready);
	modport sink (input valid, req_type, time_a, time_b, output ready);
endinterface

// ===== src/tlq_out_if.sv =====
interface tlq_out_if
	import tlq_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [FIELD_W-1:0]  on_time;
	logic [STATUS_W-1:0] status;

	modport source (output valid, on_time, status, input ready);
	modport sink (input valid, on_time, status, output ready);
endinterface

// ===== src/tlq_alu.sv =====
module tlq_alu
	import tlq_pkg::*;
#(
	parameter int W = DEF_TIME_BITS
) (
	input  alu_op_t      op,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] res,
	output logic         borrow
);

	logic [W:0] sum;

	always_comb begin
		case (op)
			ALU_ADD: sum = {1'b0, a} + {1'b0, b};
			ALU_SUB: sum = {1'b0, a} - {1'b0, b};
			default: sum = '0;
		endcase
	end

	assign res    = sum[W-1:0];
	// set on subtract when a < b
	assign borrow = (op == ALU_SUB) && sum[W];

endmodule

// ===== src/tlq_bsearch.sv =====
module tlq_bsearch
	import tlq_pkg::*;
#(
	parameter int CW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  srch_ctl_t     ctl,
	input  logic [CW-1:0] count,
	output logic [CW-1:0] probe,
	output logic [CW-1:0] lo,
	output logic          done
);

	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW:0]   sum;
	logic [CW-1:0] mid;

	assign sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid   = sum[CW:1];
	assign done  = (lo_q == hi_q);
	assign lo    = lo_q;
	// once settled, read the found entry
	assign probe = done ? lo_q : mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= '0;
			hi_q <= '0;
		end else if (ctl.init) begin
			lo_q <= '0;
			hi_q <= count;
		end else if (ctl.step && !done) begin
			if (ctl.below) begin
				lo_q <= mid + CW'(1);
			end else begin
				hi_q <= mid;
			end
		end
	end

endmodule

// ===== src/toggle_log_on_time_query_unit.sv =====
// Toggle log with on-time window queries.
//
// Input channel req (valid/ready): one word is req_type, time_a, time_b.
//   Append adds time_a as the next toggle stamp, query returns the on-time
//   inside [time_a, time_b], clear empties the log. Spans from an odd entry
//   to the next even entry count as on.
// Output channel rsp (valid/ready): one word per request, on_time and status
//   (ok, log full, stamp not increasing, bad window). on_time is 0 unless a
//   query succeeds.
// Timing: one request is worked on at a time; req.ready is high only while
//   the sequencer is idle. A query runs two binary searches, one for each
//   window end; each probe goes through a read state and a compare state,
//   bound by the single registered read port of the stamp and prefix
//   memories and the one shared subtractor that serves every compare and
//   difference.
// A finished word sits in the output register; the next request is taken
//   while it waits. If the receiver stalls, the sequencer holds its next
//   result until the register frees up.
// Reset clears the entry count and all handshake state; memory contents are
//   left as they are, and entries at or above the count never enter a result.
module toggle_log_on_time_query_unit
	import tlq_pkg::*;
#(
	parameter int LOG_DEPTH = DEF_LOG_DEPTH,
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input logic        clk,
	input logic        arst_n,
	tlq_in_if.sink     req,
	tlq_out_if.source  rsp
);

	localparam int CW = $clog2(LOG_DEPTH + 1);
	localparam int AW = $clog2(LOG_DEPTH);

	// log storage, one write and one registered read port each
	logic [TIME_BITS-1:0] stamp_mem  [LOG_DEPTH];
	logic [TIME_BITS-1:0] prefix_mem [LOG_DEPTH];
	logic [TIME_BITS-1:0] stamp_rd_q;
	logic [TIME_BITS-1:0] prefix_rd_q;

	state_t state_q, state_d;

	logic [CW-1:0]        count_q;
	logic [TIME_BITS-1:0] ta_q, tb_q;
	logic [TIME_BITS-1:0] first_stamp_q, last_stamp_q, last_prefix_q;
	logic [TIME_BITS-1:0] acc_q, cov_b_q, cov_a_q;
	logic                 pass_b_q;
	logic [TIME_BITS-1:0] res_on_q;
	status_t              res_status_q;
	logic                 out_valid_q;
	logic [FIELD_W-1:0]   out_on_q;
	status_t              out_status_q;

	alu_op_t              alu_op;
	logic [TIME_BITS-1:0] alu_a, alu_b, alu_res;
	logic                 alu_borrow;

	srch_ctl_t            bs_ctl;
	logic [CW-1:0]        bs_probe, bs_lo;
	logic                 bs_done;

	logic                 in_take;
	logic                 mem_we;
	logic [TIME_BITS-1:0] wr_prefix;
	logic                 res_load;
	logic [TIME_BITS-1:0] res_on_d;
	status_t              res_status_d;
	logic                 acc_load;
	logic                 cov_done;
	logic [TIME_BITS-1:0] cov_d;
	logic                 cov_b_load, cov_a_load;
	logic                 clr_count;
	logic                 out_load;
	logic [TIME_BITS-1:0] tgt;
	logic                 log_full;

	assign req.ready  = (state_q == S_IDLE);
	assign in_take    = req.valid && req.ready;
	assign tgt        = pass_b_q ? tb_q : ta_q;
	assign log_full   = (count_q == CW'(LOG_DEPTH));

	assign rsp.valid   = out_valid_q;
	assign rsp.on_time = out_on_q;
	assign rsp.status  = out_status_q;

	tlq_alu #(
		.W (TIME_BITS)
	) u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.res    (alu_res),
		.borrow (alu_borrow)
	);

	tlq_bsearch #(
		.CW (CW)
	) u_bsearch (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (bs_ctl),
		.count  (count_q),
		.probe  (bs_probe),
		.lo     (bs_lo),
		.done   (bs_done)
	);

	// sequencer
	always_comb begin
		state_d      = state_q;
		alu_op       = ALU_SUB;
		alu_a        = stamp_rd_q;
		alu_b        = tgt;
		bs_ctl       = '0;
		mem_we       = 1'b0;
		wr_prefix    = last_prefix_q;
		res_load     = 1'b0;
		res_on_d     = '0;
		res_status_d = ST_OK;
		acc_load     = 1'b0;
		cov_done     = 1'b0;
		cov_d        = prefix_rd_q;
		cov_b_load   = 1'b0;
		cov_a_load   = 1'b0;
		clr_count    = 1'b0;
		out_load     = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					case (req.req_type)
						REQ_APPEND: state_d = S_APP_CHK;
						REQ_QUERY: begin
							if (count_q == '0) begin
								res_load     = 1'b1;
								res_status_d = ST_BAD_WINDOW;
								state_d      = S_RESP;
							end else begin
								state_d = S_Q_CHK_LO;
							end
						end
						REQ_CLEAR: begin
							clr_count = 1'b1;
							res_load  = 1'b1;
							state_d   = S_RESP;
						end
						default: begin
							res_load = 1'b1;
							state_d  = S_RESP;
						end
					endcase
				end
			end
			S_APP_CHK: begin
				alu_a = ta_q;
				alu_b = last_stamp_q;
				if (log_full) begin
					res_load     = 1'b1;
					res_status_d = ST_FULL;
					state_d      = S_RESP;
				end else if (count_q != '0 && (alu_borrow || alu_res == '0)) begin
					res_load     = 1'b1;
					res_status_d = ST_NOT_INC;
					state_d      = S_RESP;
				end else if (count_q == '0) begin
					mem_we    = 1'b1;
					wr_prefix = '0;
					res_load  = 1'b1;
					state_d   = S_RESP;
				end else if (count_q[0]) begin
					// new entry closes an off-span: prefix carries over
					mem_we   = 1'b1;
					res_load = 1'b1;
					state_d  = S_RESP;
				end else begin
					acc_load = 1'b1;
					state_d  = S_APP_ADD;
				end
			end
			S_APP_ADD: begin
				alu_op    = ALU_ADD;
				alu_a     = last_prefix_q;
				alu_b     = acc_q;
				mem_we    = 1'b1;
				wr_prefix = alu_res;
				res_load  = 1'b1;
				state_d   = S_RESP;
			end
			S_Q_CHK_LO: begin
				alu_a = ta_q;
				alu_b = first_stamp_q;
				if (alu_borrow) begin
					res_load     = 1'b1;
					res_status_d = ST_BAD_WINDOW;
					state_d      = S_RESP;
				end else begin
					state_d = S_Q_CHK_HI;
				end
			end
			S_Q_CHK_HI: begin
				alu_a = last_stamp_q;
				alu_b = tb_q;
				if (alu_borrow) begin
					res_load     = 1'b1;
					res_status_d = ST_BAD_WINDOW;
					state_d      = S_RESP;
				end else begin
					state_d = S_Q_CHK_ORD;
				end
			end
			S_Q_CHK_ORD: begin
				alu_a = tb_q;
				alu_b = ta_q;
				if (alu_borrow) begin
					res_load     = 1'b1;
					res_status_d = ST_BAD_WINDOW;
					state_d      = S_RESP;
				end else begin
					bs_ctl.init = 1'b1;
					state_d     = S_SRCH_RD;
				end
			end
			S_SRCH_RD: begin
				// probe read goes out this cycle
				state_d = bs_done ? S_COV_DIFF : S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				bs_ctl.step  = 1'b1;
				bs_ctl.below = alu_borrow;
				state_d      = S_SRCH_RD;
			end
			S_COV_DIFF: begin
				if (bs_lo[0]) begin
					// odd entry: target sits in an off-span
					cov_done = 1'b1;
				end else begin
					acc_load = 1'b1;
					state_d  = S_COV_SUB;
				end
			end
			S_COV_SUB: begin
				alu_a    = prefix_rd_q;
				alu_b    = acc_q;
				cov_d    = alu_res;
				cov_done = 1'b1;
			end
			S_ON_SUB: begin
				alu_a    = cov_b_q;
				alu_b    = cov_a_q;
				res_load = 1'b1;
				res_on_d = alu_res;
				state_d  = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// once the end is covered, search again for the start; once the start is covered, subtract
		if (cov_done) begin
			if (pass_b_q) begin
				cov_b_load  = 1'b1;
				bs_ctl.init = 1'b1;
				state_d     = S_SRCH_RD;
			end else begin
				cov_a_load = 1'b1;
				state_d    = S_ON_SUB;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pass_b_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_count) begin
				count_q <= '0;
			end else if (mem_we) begin
				count_q <= count_q + CW'(1);
			end
			if (in_take) begin
				pass_b_q <= 1'b1;
			end else if (cov_b_load) begin
				pass_b_q <= 1'b0;
			end
			out_valid_q <= out_load || (out_valid_q && !rsp.ready);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			ta_q <= TIME_BITS'(req.time_a);
			tb_q <= TIME_BITS'(req.time_b);
		end
		if (mem_we) begin
			last_stamp_q  <= ta_q;
			last_prefix_q <= wr_prefix;
			if (count_q == '0) begin
				first_stamp_q <= ta_q;
			end
		end
		if (acc_load) begin
			acc_q <= alu_res;
		end
		if (cov_b_load) begin
			cov_b_q <= cov_d;
		end
		if (cov_a_load) begin
			cov_a_q <= cov_d;
		end
		if (res_load) begin
			res_on_q     <= res_on_d;
			res_status_q <= res_status_d;
		end
		if (out_load) begin
			out_on_q     <= FIELD_W'(res_on_q);
			out_status_q <= res_status_q;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stamp_mem[count_q[AW-1:0]]  <= ta_q;
			prefix_mem[count_q[AW-1:0]] <= wr_prefix;
		end
		stamp_rd_q  <= stamp_mem[bs_probe[AW-1:0]];
		prefix_rd_q <= prefix_mem[bs_probe[AW-1:0]];
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(LOG_DEPTH))
		else $error("entry count above log depth");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !log_full)
		else $error("log write while full");

	a_probe_in_log: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SRCH_CMP |-> bs_probe < count_q)
		else $error("search probe outside the log");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && req.req_type == REQ_CLEAR |=> count_q == '0)
		else $error("clear left entries in the log");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_on_q != '0 |-> out_status_q == ST_OK)
		else $error("nonzero on-time with error status");

endmodule
